@@ design/a_star_path_search_unit_defines.svh @@
// assertion helpers shared by the search unit
`ifndef A_STAR_PATH_SEARCH_UNIT_DEFINES_SVH
`define A_STAR_PATH_SEARCH_UNIT_DEFINES_SVH

// same-cycle implication
`define ASTAR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASTAR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/astar_pkg.sv @@
package astar_pkg;

    localparam int NUM_NODES_DEF  = 32;
    localparam int MAX_DEGREE_DEF = 8;

    localparam int SCORE_W = 22;
    localparam int PAR_W   = 6;
    localparam int DIST_W  = 18;
    localparam int RAD_W   = 36;
    localparam int COST_W  = 21;

    localparam logic [SCORE_W-1:0] INF_SCORE = '1;
    localparam logic [PAR_W-1:0]   NO_PARENT = '1;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_SETPOS = 2'd1,
        CMD_EDGE   = 2'd2,
        CMD_SEARCH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_LOADED = 2'd0,
        ST_PATH   = 2'd1,
        ST_NOPATH = 2'd2,
        ST_FULL   = 2'd3
    } status_t;

    typedef enum logic {
        CFG_START  = 1'b0,
        CFG_TARGET = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_TRD, S_TCAP, S_DRD, S_DSUB, S_DMX, S_DMY,
        S_DSQ, S_DRET, S_SCAN, S_PICK, S_NRD, S_NCHK, S_NCMP, S_PATH
    } state_t;

    // saturates one below the infinite score
    function automatic logic [SCORE_W-1:0] sat_add(input logic [SCORE_W-1:0] a,
                                                  input logic [SCORE_W-1:0] b);
        logic [SCORE_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, INF_SCORE})
            return INF_SCORE - SCORE_W'(1);
        else
            return s[SCORE_W-1:0];
    endfunction

endpackage

@@ design/a_star_path_search_unit.sv @@
// a* shortest path search over a small directed graph
// channels: command input (start/busy), plain config write port (cfg_we,
// cfg_index, cfg_data), result output marked by done for one cycle each
// an input is taken on a cycle with start high and busy low
// load commands (clear, set position, add edge) give a single result that
// shows with done in the next cycle, and busy never rises
// a search raises busy until its last result is out; results come one per
// cycle, target first, the final one with last high
// a search runs setup and the start heuristic, then per expansion an
// open-set scan over all nodes and a pick, a read and check per edge (no
// cost compare when the neighbour index is out of range) and a heuristic
// pass per improved neighbour (one shared multiplier and a 2-bit/step square root)
// path output gives one result per path node
// reset clears position valid flags, degree counts and the open set, start and target
// registers go to node 0; no clearing pass is needed
// the receiver cannot stall: every result is a transfer on its done cycle
module a_star_path_search_unit
    import astar_pkg::*;
#(
    parameter int NUM_NODES  = NUM_NODES_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data,
    input  logic [1:0]  cmd,
    input  logic [4:0]  node,
    input  logic [4:0]  other_node,
    input  logic signed [15:0] pos_x,
    input  logic signed [15:0] pos_y,
    input  logic [15:0] edge_cost,
    output logic        done,
    output logic [1:0]  status,
    output logic [4:0]  path_node,
    output logic [20:0] total_cost,
    output logic        last
);

`include "a_star_path_search_unit_defines.svh"

    localparam int NW    = (NUM_NODES > 1) ? $clog2(NUM_NODES) : 1;
    localparam int KW    = $clog2(MAX_DEGREE + 1);
    localparam int SLOTS = NUM_NODES * MAX_DEGREE;
    localparam int AW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam logic [PAR_W-1:0] NODE_LIM = PAR_W'(NUM_NODES);

    state_t state_reg, state_next;

    logic [4:0] start_node_reg, target_node_reg;

    // graph storage
    logic signed [15:0] pos_x_mem [NUM_NODES];
    logic signed [15:0] pos_y_mem [NUM_NODES];
    logic [4:0]         nbr_idx_mem  [SLOTS];
    logic [15:0]        nbr_cost_mem [SLOTS];
    logic [NUM_NODES-1:0] pos_valid_reg;
    logic [KW-1:0]      deg_reg [NUM_NODES];

    // search state
    logic [SCORE_W-1:0] g_reg [NUM_NODES];
    logic [SCORE_W-1:0] f_reg [NUM_NODES];
    logic [PAR_W-1:0]   par_reg [NUM_NODES];
    logic [NUM_NODES-1:0] open_reg;

    logic signed [15:0] pos_x_q, pos_y_q;
    logic               pos_v_q;
    logic [4:0]         nidx_q;
    logic [15:0]        ncost_q;

    logic signed [15:0] tx_reg, ty_reg;
    logic [NW-1:0]      dn_reg;
    logic               dret_reg;
    logic [15:0]        ax_reg, ay_reg;
    logic [31:0]        sq_reg;
    logic [RAD_W-1:0]   rad_reg, root_reg, bit_reg;

    logic [NW-1:0]      idx_reg, u_reg, v_reg;
    logic               any_reg;
    logic [SCORE_W-1:0] best_f_reg, g_u_reg, tg_reg;
    logic [KW-1:0]      k_reg;
    logic [PAR_W-1:0]   cur_reg;
    logic [NW-1:0]      n_reg;

    logic               done_reg;
    status_t            status_reg;
    logic [4:0]         path_node_reg;
    logic [COST_W-1:0]  cost_reg;
    logic               last_reg;

    // combinational helpers
    logic               accept;
    logic               node_ok, other_ok, start_ok, target_ok;
    logic [NW-1:0]      deg_addr;
    logic [KW-1:0]      deg_sel;
    logic [NW-1:0]      g_addr;
    logic [SCORE_W-1:0] g_sel;
    logic [AW-1:0]      wr_slot, rd_slot;
    logic               pos_we, nbr_we;
    logic               nbr_more, nbr_bad, improve, scan_end, path_end;
    logic [RAD_W-1:0]   trial;
    logic               sq_fits;
    logic signed [16:0] dx, dy;
    logic [PAR_W-1:0]   par_cur;
    logic               cur_end_in;
    logic [15:0]        mul_op;
    logic [31:0]        mul_out;

    assign accept    = start && !busy;
    assign node_ok   = {1'b0, node} < NODE_LIM;
    assign other_ok  = {1'b0, other_node} < NODE_LIM;
    assign start_ok  = {1'b0, start_node_reg} < NODE_LIM;
    assign target_ok = {1'b0, target_node_reg} < NODE_LIM;

    assign deg_addr = (state_reg == S_IDLE) ? node[NW-1:0] : u_reg;
    assign deg_sel  = deg_reg[deg_addr];
    assign g_addr   = (state_reg == S_PICK) ? u_reg : v_reg;
    assign g_sel    = g_reg[g_addr];

    assign wr_slot = AW'(node[NW-1:0] * MAX_DEGREE) + AW'(deg_sel);
    assign rd_slot = AW'(u_reg * MAX_DEGREE) + AW'(k_reg);

    assign pos_we = accept && cmd_t'(cmd) == CMD_SETPOS && node_ok;
    assign nbr_we = accept && cmd_t'(cmd) == CMD_EDGE && node_ok && other_ok
                    && (deg_sel < KW'(MAX_DEGREE));

    assign nbr_more = (k_reg < deg_sel) && (k_reg < KW'(MAX_DEGREE));
    assign nbr_bad  = {1'b0, nidx_q} >= NODE_LIM;
    assign improve  = tg_reg < g_sel;
    assign scan_end = idx_reg == NW'(NUM_NODES - 1);

    assign par_cur    = par_reg[cur_reg[NW-1:0]];
    assign cur_end_in = par_cur >= NODE_LIM;
    assign path_end   = cur_end_in || (n_reg == NW'(NUM_NODES - 1));

    assign trial   = root_reg + bit_reg;
    assign sq_fits = rad_reg >= trial;

    assign dx = {pos_x_q[15], pos_x_q} - {tx_reg[15], tx_reg};
    assign dy = {pos_y_q[15], pos_y_q} - {ty_reg[15], ty_reg};

    // one squarer shared by both axes
    assign mul_op  = (state_reg == S_DMY) ? ay_reg : ax_reg;
    assign mul_out = mul_op * mul_op;

    assign busy       = state_reg != S_IDLE;
    assign done       = done_reg;
    assign status     = status_reg;
    assign path_node  = path_node_reg;
    assign total_cost = cost_reg;
    assign last       = last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && cmd_t'(cmd) == CMD_SEARCH && start_ok && target_ok)
                    state_next = S_INIT;
            end
            S_INIT: state_next = S_TRD;
            S_TRD:  state_next = S_TCAP;
            S_TCAP: state_next = S_DRD;
            S_DRD:  state_next = S_DSUB;
            S_DSUB: state_next = S_DMX;
            S_DMX:  state_next = S_DMY;
            S_DMY:  state_next = S_DSQ;
            S_DSQ:
            begin
                if (bit_reg[0])
                    state_next = S_DRET;
            end
            S_DRET: state_next = dret_reg ? S_NRD : S_SCAN;
            S_SCAN:
            begin
                if (scan_end)
                    state_next = S_PICK;
            end
            S_PICK:
            begin
                if (!any_reg)
                    state_next = S_IDLE;
                else if ({1'b0, u_reg} == {1'b0, target_node_reg[NW-1:0]})
                    state_next = S_PATH;
                else
                    state_next = S_NRD;
            end
            S_NRD:  state_next = nbr_more ? S_NCHK : S_SCAN;
            S_NCHK: state_next = nbr_bad ? S_NRD : S_NCMP;
            S_NCMP: state_next = improve ? S_DRD : S_NRD;
            S_PATH:
            begin
                if (path_end)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_node_reg  <= '0;
            target_node_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_START:  start_node_reg  <= cfg_data;
                CFG_TARGET: target_node_reg <= cfg_data;
                default:    start_node_reg  <= start_node_reg;
            endcase
        end
    end

    // position and neighbour memories, registered reads
    always_ff @(posedge clk)
    begin
        if (pos_we)
        begin
            pos_x_mem[node[NW-1:0]] <= pos_x;
            pos_y_mem[node[NW-1:0]] <= pos_y;
        end
        pos_x_q <= pos_x_mem[dn_reg];
        pos_y_q <= pos_y_mem[dn_reg];
    end

    always_ff @(posedge clk)
    begin
        if (nbr_we)
        begin
            nbr_idx_mem[wr_slot]  <= other_node;
            nbr_cost_mem[wr_slot] <= edge_cost;
        end
        nidx_q  <= nbr_idx_mem[rd_slot];
        ncost_q <= nbr_cost_mem[rd_slot];
    end

    // graph control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_valid_reg <= '0;
            pos_v_q       <= 1'b0;
            for (int i = 0; i < NUM_NODES; i++)
                deg_reg[i] <= '0;
        end
        else
        begin
            pos_v_q <= pos_valid_reg[dn_reg];
            if (accept && cmd_t'(cmd) == CMD_CLEAR)
            begin
                pos_valid_reg <= '0;
                for (int i = 0; i < NUM_NODES; i++)
                    deg_reg[i] <= '0;
            end
            if (pos_we)
                pos_valid_reg[node[NW-1:0]] <= 1'b1;
            if (nbr_we)
                deg_reg[node[NW-1:0]] <= deg_sel + KW'(1);
        end
    end

    // open set
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            open_reg <= '0;
        else if (state_reg == S_INIT)
            open_reg <= NUM_NODES'(1) << start_node_reg[NW-1:0];
        else if (state_reg == S_PICK && any_reg)
            open_reg[u_reg] <= 1'b0;
        else if (state_reg == S_DRET && dret_reg)
            open_reg[v_reg] <= 1'b1;
    end

    // scores and parent links
    always_ff @(posedge clk)
    begin
        if (state_reg == S_INIT)
        begin
            for (int i = 0; i < NUM_NODES; i++)
            begin
                g_reg[i]   <= (NW'(i) == start_node_reg[NW-1:0]) ? '0 : INF_SCORE;
                f_reg[i]   <= INF_SCORE;
                par_reg[i] <= NO_PARENT;
            end
        end
        else if (state_reg == S_DRET)
        begin
            if (dret_reg)
            begin
                g_reg[v_reg]   <= tg_reg;
                f_reg[v_reg]   <= sat_add(tg_reg, SCORE_W'(root_reg[DIST_W-1:0]));
                par_reg[v_reg] <= PAR_W'(u_reg);
            end
            else
                f_reg[start_node_reg[NW-1:0]] <= SCORE_W'(root_reg[DIST_W-1:0]);
        end
    end

    // heuristic unit, scan and relaxation datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            S_INIT:
                dn_reg <= target_node_reg[NW-1:0];
            S_TCAP:
            begin
                tx_reg   <= pos_v_q ? pos_x_q : 16'sd0;
                ty_reg   <= pos_v_q ? pos_y_q : 16'sd0;
                dn_reg   <= start_node_reg[NW-1:0];
                dret_reg <= 1'b0;
            end
            S_DSUB:
            begin
                // unwritten positions read as zero
                if (pos_v_q)
                begin
                    ax_reg <= dx[16] ? 16'(-dx) : dx[15:0];
                    ay_reg <= dy[16] ? 16'(-dy) : dy[15:0];
                end
                else
                begin
                    ax_reg <= tx_reg[15] ? 16'(-{tx_reg[15], tx_reg}) : tx_reg;
                    ay_reg <= ty_reg[15] ? 16'(-{ty_reg[15], ty_reg}) : ty_reg;
                end
            end
            S_DMX:
                sq_reg <= mul_out;
            S_DMY:
            begin
                rad_reg  <= RAD_W'(sq_reg) + RAD_W'(mul_out);
                root_reg <= '0;
                bit_reg  <= RAD_W'(1) << 34;
            end
            S_DSQ:
            begin
                // one result bit and two radicand bits per step
                if (sq_fits)
                begin
                    rad_reg  <= rad_reg - trial;
                    root_reg <= (root_reg >> 1) + bit_reg;
                end
                else
                    root_reg <= root_reg >> 1;
                bit_reg <= bit_reg >> 2;
            end
            S_DRET:
            begin
                idx_reg <= '0;
                any_reg <= 1'b0;
                if (dret_reg)
                    k_reg <= k_reg + KW'(1);
            end
            S_SCAN:
            begin
                if (open_reg[idx_reg] && (!any_reg || f_reg[idx_reg] < best_f_reg))
                begin
                    u_reg      <= idx_reg;
                    best_f_reg <= f_reg[idx_reg];
                    any_reg    <= 1'b1;
                end
                idx_reg <= idx_reg + NW'(1);
            end
            S_PICK:
            begin
                g_u_reg <= g_sel;
                k_reg   <= '0;
                cur_reg <= PAR_W'(target_node_reg);
                n_reg   <= '0;
            end
            S_NRD:
            begin
                idx_reg <= '0;
                any_reg <= 1'b0;
            end
            S_NCHK:
            begin
                v_reg  <= nidx_q[NW-1:0];
                tg_reg <= sat_add(g_u_reg, SCORE_W'(ncost_q));
                if (nbr_bad)
                    k_reg <= k_reg + KW'(1);
            end
            S_NCMP:
            begin
                dn_reg   <= v_reg;
                dret_reg <= 1'b1;
                if (!improve)
                    k_reg <= k_reg + KW'(1);
            end
            S_PATH:
            begin
                cur_reg <= par_cur;
                n_reg   <= n_reg + NW'(1);
            end
            default:
                dn_reg <= dn_reg;
        endcase
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= (accept && !(cmd_t'(cmd) == CMD_SEARCH && start_ok && target_ok))
                        || (state_reg == S_PICK && !any_reg)
                        || (state_reg == S_PATH);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_PATH)
        begin
            status_reg    <= ST_PATH;
            path_node_reg <= cur_reg[4:0];
            cost_reg      <= g_u_reg[COST_W-1:0];
            last_reg      <= path_end;
        end
        else
        begin
            path_node_reg <= '0;
            cost_reg      <= '0;
            last_reg      <= 1'b1;
            if (state_reg == S_PICK)
                status_reg <= ST_NOPATH;
            else if (accept && cmd_t'(cmd) == CMD_SEARCH)
                status_reg <= ST_NOPATH;
            else if (accept && cmd_t'(cmd) == CMD_EDGE && node_ok && other_ok
                     && !(deg_sel < KW'(MAX_DEGREE)))
                status_reg <= ST_FULL;
            else
                status_reg <= ST_LOADED;
        end
    end

    `ASTAR_ASSERT_NEXT(a_path_emits, state_reg == S_PATH, done && status == ST_PATH, "path step without result")
    `ASTAR_ASSERT_NOW(a_single_last, done && status != ST_PATH, last, "non-path result not marked last")
    `ASTAR_ASSERT_NOW(a_nopath_zero, done && status == ST_NOPATH, path_node == '0 && total_cost == '0, "no-path result carries data")

endmodule
